### rtl/core/rwc_pkg.sv
// types, constants and configuration helpers shared by the window crop modules
package rwc_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int DIM_W   = 13;
	localparam int COORD_W = 12;
	localparam int BPP_W   = 2;
	localparam int BYTE_W  = 14;
	localparam int DATA_W  = 8;
	localparam int PAD_W   = 2;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 13;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [IDX_W-1:0] {
		REG_IMAGE_WIDTH     = 3'd0,
		REG_IMAGE_HEIGHT    = 3'd1,
		REG_BYTES_PER_PIXEL = 3'd2,
		REG_WINDOW_LEFT     = 3'd3,
		REG_WINDOW_RIGHT    = 3'd4,
		REG_WINDOW_BOTTOM   = 3'd5,
		REG_WINDOW_TOP      = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic [DIM_W-1:0]   image_width;
		logic [DIM_W-1:0]   image_height;
		logic [BPP_W-1:0]   bytes_per_pixel;
		logic [COORD_W-1:0] window_left;
		logic [COORD_W-1:0] window_right;
		logic [COORD_W-1:0] window_bottom;
		logic [COORD_W-1:0] window_top;
	} cfg_raw_t;

	typedef struct packed {
		logic               win_ok;
		logic [COORD_W-1:0] row_first;
		logic [COORD_W-1:0] row_last;
		logic [COORD_W-1:0] height_last;
		logic [BYTE_W-1:0]  byte_first;
		logic [BYTE_W-1:0]  byte_last;
		logic [BYTE_W-1:0]  src_last;
		logic [PAD_W-1:0]   row_pad;
	} cfg_geom_t;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [PAD_W-1:0]  pad;
		logic              last;
	} entry_t;

	localparam cfg_raw_t CFG_RESET = '{
		image_width:     13'd1,
		image_height:    13'd1,
		bytes_per_pixel: 2'd3,
		window_left:     12'd0,
		window_right:    12'd0,
		window_bottom:   12'd0,
		window_top:      12'd0
	};

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
		logic [DIM_W-1:0] res;
		if (v == '0) begin
			res = DIM_W'(1);
		end else if (int'(v) > maxv) begin
			res = DIM_W'(maxv);
		end else begin
			res = v;
		end
		return res;
	endfunction

	function automatic logic [PAD_W-1:0] pad_of(input logic [1:0] n);
		return PAD_W'(3'd4 - {1'b0, n});
	endfunction

	function automatic logic [BYTE_W-1:0] times_bpp(input logic [DIM_W-1:0] x, input logic three);
		logic [BYTE_W-1:0] xe;
		xe = BYTE_W'(x);
		return (xe << 1) + (three ? xe : '0);
	endfunction

	function automatic cfg_geom_t derive(input cfg_raw_t c);
		cfg_geom_t        g;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [DIM_W-1:0] wm1;
		logic [DIM_W-1:0] hm1;
		logic [DIM_W-1:0] l;
		logic [DIM_W-1:0] r;
		logic [DIM_W-1:0] b;
		logic [DIM_W-1:0] t;
		logic             three;
		logic [BYTE_W-1:0] wb;
		logic [BYTE_W-1:0] endb;
		logic [1:0]       n2;
		logic [3:0]       nb;
		w     = clamp_dim(c.image_width, MAX_WIDTH);
		h     = clamp_dim(c.image_height, MAX_HEIGHT);
		wm1   = w - DIM_W'(1);
		hm1   = h - DIM_W'(1);
		l     = (DIM_W'(c.window_left) > wm1) ? wm1 : DIM_W'(c.window_left);
		r     = (DIM_W'(c.window_right) > wm1) ? wm1 : DIM_W'(c.window_right);
		b     = (DIM_W'(c.window_bottom) > hm1) ? hm1 : DIM_W'(c.window_bottom);
		t     = (DIM_W'(c.window_top) > hm1) ? hm1 : DIM_W'(c.window_top);
		three = (c.bytes_per_pixel != 2'd2);
		wb    = times_bpp(w, three);
		endb  = times_bpp(r + DIM_W'(1), three);
		n2    = 2'(r - l + DIM_W'(1));
		nb    = 4'(n2) * (three ? 4'd3 : 4'd2);
		g.win_ok      = (l <= r) && (b <= t);
		g.row_first   = COORD_W'(b);
		g.row_last    = COORD_W'(t);
		g.height_last = COORD_W'(hm1);
		g.byte_first  = times_bpp(l, three);
		g.byte_last   = endb - BYTE_W'(1);
		g.src_last    = wb + BYTE_W'(pad_of(wb[1:0])) - BYTE_W'(1);
		g.row_pad     = pad_of(nb[1:0]);
		return g;
	endfunction

endpackage

### rtl/core/rwc_front.sv
// front end: byte and row counters, window test and request classification
module rwc_front import rwc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_geom_t         geom,
	input  logic              cfg_busy,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [DATA_W-1:0] source_byte,
	input  logic              q_full,
	output logic              q_push,
	output entry_t            q_entry
);

	logic [BYTE_W-1:0]  byte_in_row_q;
	logic [COORD_W-1:0] row_index_q;
	logic               accept;
	logic               keep;
	logic               row_end;

	assign in_stall = q_full || cfg_busy;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		keep = geom.win_ok
			&& (row_index_q >= geom.row_first) && (row_index_q <= geom.row_last)
			&& (byte_in_row_q >= geom.byte_first) && (byte_in_row_q <= geom.byte_last);
		row_end = (byte_in_row_q == geom.byte_last);
		q_entry.data = source_byte;
		q_entry.pad  = row_end ? geom.row_pad : '0;
		q_entry.last = row_end && (row_index_q == geom.row_last);
	end

	assign q_push = accept && keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in_row_q <= '0;
			row_index_q   <= '0;
		end else if (accept) begin
			if (byte_in_row_q >= geom.src_last) begin
				byte_in_row_q <= '0;
				if (row_index_q >= geom.height_last) begin
					row_index_q <= '0;
				end else begin
					row_index_q <= row_index_q + COORD_W'(1);
				end
			end else begin
				byte_in_row_q <= byte_in_row_q + BYTE_W'(1);
			end
		end
	end

endmodule

### rtl/core/rwc_queue.sv
// small request queue between the front end and the output sequencer
module rwc_queue import rwc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output entry_t head
);

	entry_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue pushed while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("queue popped while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + QCNT_W'(1)))
		else $error("queue count lost a push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == QPTR_W'(count_q))
		else $error("queue pointers disagree with count");
`endif

endmodule

### rtl/core/rwc_back.sv
// back end: emits each kept byte and its row padding through an output register
module rwc_back import rwc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  entry_t            q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] crop_byte,
	output logic              is_padding,
	output logic              last_of_image
);

	logic              out_valid_q;
	logic [DATA_W-1:0] crop_byte_q;
	logic              is_padding_q;
	logic              last_q;
	logic [PAD_W-1:0]  pad_left_q;
	logic              pad_last_q;
	logic              load;
	logic              pad_busy;

	assign load     = !out_valid_q || !out_stall;
	assign pad_busy = (pad_left_q != '0);
	assign q_pop    = load && !pad_busy && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pad_left_q  <= '0;
			pad_last_q  <= 1'b0;
		end else if (load) begin
			if (pad_busy) begin
				out_valid_q <= 1'b1;
				pad_left_q  <= pad_left_q - PAD_W'(1);
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				pad_left_q  <= q_head.pad;
				pad_last_q  <= q_head.last;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pad_busy) begin
				crop_byte_q  <= '0;
				is_padding_q <= 1'b1;
				last_q       <= pad_last_q && (pad_left_q == PAD_W'(1));
			end else begin
				crop_byte_q  <= q_head.data;
				is_padding_q <= 1'b0;
				last_q       <= q_head.last && (q_head.pad == '0);
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign crop_byte     = crop_byte_q;
	assign is_padding    = is_padding_q;
	assign last_of_image = last_q;

`ifndef NO_ASSERTIONS
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_padding_q) |-> (crop_byte_q == '0))
		else $error("padding byte not zero");
	a_no_pop_in_pad: assert property (@(posedge clk) disable iff (!arst_n)
		pad_busy |-> !q_pop)
		else $error("request taken while padding pending");
	a_pad_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(load && pad_busy) |=> (out_valid_q && is_padding_q))
		else $error("pending padding not emitted");
`endif

endmodule

### rtl/core/raster_window_crop.sv
// top level of the raster window crop: config registers, front end, queue, back end
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    source_byte
//  out      output     out_valid / out_stall  crop_byte, is_padding, last_of_image
//  cfg      input      cfg_we                 cfg_index, cfg_data
//
// one source byte is taken per cycle while the four-entry queue has room and cfg_busy is low
// a kept byte with row padding holds the output sequencer through its pad bytes (at most 3)
// an output stall backs up the queue and then raises in_stall; dropped bytes need no slot
// reset clears counters, queue and output; config returns to its reset values
// a config write reaches cfg_q, then geom_q; cfg_we and cfg_settle_q hold in_stall meanwhile
module raster_window_crop import rwc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [DATA_W-1:0] source_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] crop_byte,
	output logic              is_padding,
	output logic              last_of_image
);

	cfg_raw_t  cfg_q;
	cfg_geom_t geom_q;
	logic      cfg_settle_q;
	logic      cfg_busy;
	logic      q_full;
	logic      q_empty;
	logic      q_push;
	logic      q_pop;
	entry_t    q_entry;
	entry_t    q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:     cfg_q.image_width     <= cfg_data;
				REG_IMAGE_HEIGHT:    cfg_q.image_height    <= cfg_data;
				REG_BYTES_PER_PIXEL: cfg_q.bytes_per_pixel <= cfg_data[BPP_W-1:0];
				REG_WINDOW_LEFT:     cfg_q.window_left     <= cfg_data[COORD_W-1:0];
				REG_WINDOW_RIGHT:    cfg_q.window_right    <= cfg_data[COORD_W-1:0];
				REG_WINDOW_BOTTOM:   cfg_q.window_bottom   <= cfg_data[COORD_W-1:0];
				REG_WINDOW_TOP:      cfg_q.window_top      <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q <= derive(CFG_RESET);
		end else begin
			geom_q <= derive(cfg_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_settle_q <= 1'b0;
		end else begin
			cfg_settle_q <= cfg_we;
		end
	end

	assign cfg_busy = cfg_we || cfg_settle_q;

	rwc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.geom        (geom_q),
		.cfg_busy    (cfg_busy),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.source_byte (source_byte),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (q_entry)
	);

	rwc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (q_head)
	);

	rwc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.crop_byte     (crop_byte),
		.is_padding    (is_padding),
		.last_of_image (last_of_image)
	);

endmodule
